### hw/rtl/c2p_pkg.sv
package c2p_pkg;

  localparam int FIELD_WIDTH         = 16;
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ITERATIONS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int TBL_FRAC            = 20;
  localparam int TBL_SIZE            = 32;
  localparam int ANGLE_ACC_WIDTH     = 32;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] x_coord;
    logic signed [FIELD_WIDTH-1:0] y_coord;
  } in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] radius;
    logic [FIELD_WIDTH-1:0] angle;
    logic                   zero_point;
  } out_t;

  // atan(2^-i) in degrees, TBL_FRAC fraction bits, rounded to nearest
  function automatic logic signed [ANGLE_ACC_WIDTH-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANGLE_ACC_WIDTH-1:0] v;
    case (idx)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      5'd24:   v = 32'sd4;
      5'd25:   v = 32'sd2;
      5'd26:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/cartesian_to_polar_top.sv
// cartesian to polar converter, fully pipelined
//
// in channel: in_valid / in_stall carry one point (x_coord, y_coord, signed) per
// request. out channel: out_valid / out_stall carry radius (truncated length),
// angle (atan2 in 2^-ANGLE_FRAC_BITS degree units, 0 up to under 360 degrees)
// and zero_point, which is set for the origin with radius and angle forced to 0.
//
// throughput: one point per cycle while out_stall is low; each step stage holds
// one cordic rotation (the first ITERATIONS of them) and one digit of the
// integer square root (the first COORD_WIDTH of them).
//
// reset (rst_n low, synchronous) empties the pipeline; no results are pending
// afterwards. when the receiver stalls, the output register holds its result
// and the pipeline keeps accepting until every stage is full; empty stages
// close up, so in_stall rises only once all stages hold a point.
module cartesian_to_polar_top #(
  parameter int COORD_WIDTH     = c2p_pkg::COORD_WIDTH_DEF,
  parameter int ITERATIONS      = c2p_pkg::ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS = c2p_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  c2p_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output c2p_pkg::out_t out_data
);

  localparam int W     = COORD_WIDTH;
  localparam int N     = (ITERATIONS > COORD_WIDTH) ? ITERATIONS : COORD_WIDTH;
  localparam int NS    = N + 4;
  localparam int GUARD = 60 - COORD_WIDTH;
  localparam int DW    = 63;
  localparam int ZW    = c2p_pkg::ANGLE_ACC_WIDTH;
  localparam int RW    = W + 2;
  localparam int SH    = c2p_pkg::TBL_FRAC - ANGLE_FRAC_BITS;
  localparam int FW    = c2p_pkg::FIELD_WIDTH;

  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360 * (1 << c2p_pkg::TBL_FRAC));
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * (1 << c2p_pkg::TBL_FRAC));
  localparam logic signed [ZW-1:0] ROUND_BIT = ZW'(1 << (SH - 1));
  localparam logic signed [ZW-1:0] ANGLE_MAX = ZW'(360 * (1 << ANGLE_FRAC_BITS));

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [2*W-1:0]       n;
    logic [RW-1:0]        rem;
    logic [W-1:0]         root;
    logic                 zero;
  } stg_t;

  // handshake: a stage loads when it is empty or its successor moves on
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0: take the low bits of each field, fold into the right half plane
  logic [31:0]          raw_x, raw_y;
  logic signed [W-1:0]  sx, sy;
  logic signed [DW-1:0] xe, ye, ax_full, ay_full;
  logic                 neg;

  logic signed [DW-1:0] cx0_r, cy0_r, cx0_nxt, cy0_nxt;
  logic signed [ZW-1:0] cz0_r, cz0_nxt;
  logic [W-1:0]         ax0_r, ay0_r;
  logic                 zero0_r;

  always_comb begin
    raw_x   = {16'b0, in_data.x_coord};
    raw_y   = {16'b0, in_data.y_coord};
    sx      = signed'(raw_x[W-1:0]);
    sy      = signed'(raw_y[W-1:0]);
    xe      = DW'(sx);
    ye      = DW'(sy);
    neg     = xe < 0;
    ax_full = neg ? -xe : xe;
    ay_full = (ye < 0) ? -ye : ye;
    cx0_nxt = (neg ? -xe : xe) <<< GUARD;
    cy0_nxt = (neg ? -ye : ye) <<< GUARD;
    cz0_nxt = neg ? HALF_TURN : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cx0_r   <= cx0_nxt;
      cy0_r   <= cy0_nxt;
      cz0_r   <= cz0_nxt;
      ax0_r   <= ax_full[W-1:0];
      ay0_r   <= ay_full[W-1:0];
      zero0_r <= (sx == '0) && (sy == '0);
    end
  end

  // stage 1: squares
  logic signed [DW-1:0] cx1_r, cy1_r;
  logic signed [ZW-1:0] cz1_r;
  logic [2*W-1:0]       sqx1_r, sqy1_r;
  logic                 zero1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cx1_r   <= cx0_r;
      cy1_r   <= cy0_r;
      cz1_r   <= cz0_r;
      sqx1_r  <= (2*W)'(ax0_r) * (2*W)'(ax0_r);
      sqy1_r  <= (2*W)'(ay0_r) * (2*W)'(ay0_r);
      zero1_r <= zero0_r;
    end
  end

  // stage 2: sum of squares, seeds the step stages
  stg_t seed_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      seed_r.x    <= cx1_r;
      seed_r.y    <= cy1_r;
      seed_r.z    <= cz1_r;
      seed_r.n    <= sqx1_r + sqy1_r;
      seed_r.rem  <= '0;
      seed_r.root <= '0;
      seed_r.zero <= zero1_r;
    end
  end

  // step stages: a cordic rotation in each of the first ITERATIONS, a root digit in each of the first W
  stg_t st_r   [N];
  stg_t st_nxt [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    stg_t          src;
    logic [RW-1:0] sh_rem, trial;
    logic          ge;

    always_comb begin
      src        = (k == 0) ? seed_r : st_r[(k == 0) ? 0 : k - 1];
      st_nxt[k]  = src;
      sh_rem     = {src.rem[RW-3:0], src.n[2*W-1:2*W-2]};
      trial      = {src.root, 2'b01};
      ge         = sh_rem >= trial;
      if (k < ITERATIONS) begin
        // y >= 0 rotates clockwise
        if (src.y >= 0) begin
          st_nxt[k].x = src.x + (src.y >>> k);
          st_nxt[k].y = src.y - (src.x >>> k);
          st_nxt[k].z = src.z + c2p_pkg::atan_entry(5'(k));
        end else begin
          st_nxt[k].x = src.x - (src.y >>> k);
          st_nxt[k].y = src.y + (src.x >>> k);
          st_nxt[k].z = src.z - c2p_pkg::atan_entry(5'(k));
        end
      end
      if (k < W) begin
        st_nxt[k].n    = {src.n[2*W-3:0], 2'b00};
        st_nxt[k].rem  = ge ? (sh_rem - trial) : sh_rem;
        st_nxt[k].root = {src.root[W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k+3]) st_r[k] <= st_nxt[k];
    end
  end

  // output stage: wrap, round and saturate
  logic signed [ZW-1:0] zp, za, zs;
  logic [47:0]          root_ext;
  c2p_pkg::out_t        out_nxt, out_r;

  always_comb begin
    zp       = (st_r[N-1].z < 0) ? st_r[N-1].z + FULL_TURN : st_r[N-1].z;
    za       = (zp + ROUND_BIT) >>> SH;
    zs       = (za >= ANGLE_MAX) ? za - ANGLE_MAX : za;
    root_ext = 48'(st_r[N-1].root);
    if (st_r[N-1].zero) begin
      out_nxt.radius     = '0;
      out_nxt.angle      = '0;
      out_nxt.zero_point = 1'b1;
    end else begin
      out_nxt.radius     = (root_ext > 48'hFFFF) ? {FW{1'b1}} : root_ext[FW-1:0];
      out_nxt.angle      = zs[FW-1:0];
      out_nxt.zero_point = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### bench/tb_cartesian_to_polar_top.sv
module tb_cartesian_to_polar_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 20;
  localparam int DRAIN_CYCLES = 3 * LATENCY;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_POINTS = 800;

  // cordic set-up at the block's default parameters
  localparam int STEPS       = c2p_pkg::ITERATIONS_DEF;
  localparam int GUARD_BITS  = 60 - c2p_pkg::COORD_WIDTH_DEF;
  localparam int ROUND_SHIFT = c2p_pkg::TBL_FRAC - c2p_pkg::ANGLE_FRAC_BITS_DEF;
  localparam longint HALF_TURN = longint'(180) <<< c2p_pkg::TBL_FRAC;
  localparam longint FULL_TURN = longint'(360) <<< c2p_pkg::TBL_FRAC;
  localparam longint ANGLE_WRAP = longint'(360) <<< c2p_pkg::ANGLE_FRAC_BITS_DEF;

  // atan(2^-i) in degrees with 20 fraction bits
  localparam longint ATAN_DEG [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  c2p_pkg::in_t  in_data  = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  c2p_pkg::out_t out_data;

  c2p_pkg::out_t polar_expected [$];
  c2p_pkg::in_t  request_points [$];

  int mismatches     = 0;
  int points_sent    = 0;
  int origins_sent   = 0;
  int results_checked = 0;
  int burst_left     = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int run_left  = 0;

  cartesian_to_polar_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic c2p_pkg::out_t predict_polar(c2p_pkg::in_t pt);
    c2p_pkg::out_t res;
    longint px, py, ax, ay, dx, dy, acc, ang;
    longint unsigned rem, root, bitv;
    res = '0;
    px = pt.x_coord;
    py = pt.y_coord;
    if (px == 0 && py == 0) begin
      res.zero_point = 1'b1;
      return res;
    end

    // exact integer square root of x*x + y*y
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    rem = ax * ax + ay * ay;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root > 64'hFFFF) root = 64'hFFFF;

    // left half plane folds onto the right with 180 degrees preloaded
    acc = 0;
    if (px < 0) begin
      px = -px;
      py = -py;
      acc = HALF_TURN;
    end
    px = px <<< GUARD_BITS;
    py = py <<< GUARD_BITS;

    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx;
        py -= dy;
        acc += ATAN_DEG[i];
      end else begin
        px -= dx;
        py += dy;
        acc -= ATAN_DEG[i];
      end
    end

    if (acc < 0) acc += FULL_TURN;
    ang = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (ang >= ANGLE_WRAP) ang -= ANGLE_WRAP;

    res.radius = root[15:0];
    res.angle  = ang[15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(input c2p_pkg::out_t got);
    c2p_pkg::out_t want;
    c2p_pkg::in_t  pt;
    if (polar_expected.size() == 0) begin
      report_mismatch($sformatf("result r=%0d a=%0d z=%0b with no request pending",
                                got.radius, got.angle, got.zero_point));
      return;
    end
    want = polar_expected.pop_front();
    pt   = request_points.pop_front();
    results_checked++;
    if (got.radius !== want.radius)
      report_mismatch($sformatf("(%0d,%0d) radius %0d, expected %0d",
                                pt.x_coord, pt.y_coord, got.radius, want.radius));
    if (got.angle !== want.angle)
      report_mismatch($sformatf("(%0d,%0d) angle %0d, expected %0d",
                                pt.x_coord, pt.y_coord, got.angle, want.angle));
    if (got.zero_point !== want.zero_point)
      report_mismatch($sformatf("(%0d,%0d) zero_point %0b, expected %0b",
                                pt.x_coord, pt.y_coord, got.zero_point, want.zero_point));
  endtask

  // sender works in bursts; a gap may open before each new burst
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    c2p_pkg::in_t pt;
    int  gap;
    pt.x_coord = x;
    pt.y_coord = y;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (in_stall);
    polar_expected.push_back(predict_polar(pt));
    request_points.push_back(pt);
    points_sent++;
    if (x == 0 && y == 0) origins_sent++;
  endtask

  // result side: check, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (run_left == 0) begin
            out_stall <= ~out_stall;
            run_left  <= $urandom_range(1, 40);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic test_origin();
    send_point(16'sd0, 16'sd0);
    send_point(16'sd5, -16'sd3);
    send_point(16'sd0, 16'sd0);
  endtask

  task automatic test_axes();
    send_point(16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sd0, -16'sd1);
    send_point(16'sd32767, 16'sd0);
    send_point(-16'sd32768, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(16'sd0, -16'sd32768);
  endtask

  task automatic test_extremes();
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd3, 16'sd4);
  endtask

  // rounding up to a full turn wraps to zero; points either side of 180
  task automatic test_angle_wrap();
    send_point(16'sd32767, -16'sd1);
    send_point(-16'sd32768, -16'sd1);
    send_point(-16'sd32768, 16'sd1);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
  endtask

  task automatic test_random_points();
    logic signed [15:0] x, y;
    int t;
    repeat (RANDOM_POINTS) begin
      x = 16'($urandom);
      y = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4: begin
          t = $urandom_range(0, 16);
          x = 16'(t - 8);
          t = $urandom_range(0, 16);
          y = 16'(t - 8);
        end
        5: begin
          if ($urandom_range(0, 1)) x = '0;
          else y = '0;
        end
        6: begin
          y = $urandom_range(0, 1) ? x : -x;
        end
        7: begin
          t = $urandom_range(0, 3);
          x = (t == 0) ? -16'sd32768 : (t == 1) ? -16'sd32767 :
              (t == 2) ? 16'sd32766 : 16'sd32767;
        end
        default: begin
          // near the horizontal axis, where the angle lies near 0, 180 or 360
          t = $urandom_range(0, 4);
          y = 16'(t - 2);
        end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_origin();
    test_axes();
    test_extremes();
    test_angle_wrap();
    test_random_points();

    in_valid <= 1'b0;
    while (polar_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d points sent (%0d at the origin), %0d results checked",
             points_sent, origins_sent, results_checked);
    $display("summary: axes, extremes, angle wrap and random points under random stalls");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
